@@ sv/assert_macros.svh @@
// Assertion helpers shared by the filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define RCV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define RCV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RCV_ASSERT(lbl, clk, rst, prop, msg)
`define RCV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ sv/rcv_pkg.sv @@
// ----------------------------------------------------------------------------
// rcv_pkg
// Types and constants of the 3x3 RGB convolution stream.
// ----------------------------------------------------------------------------
package rcv_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int COEF_W     = 16;
  localparam int PIX_W      = 24;
  localparam int PROD_W     = 25;
  localparam int SUM_W      = 29;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd4;

  localparam logic [10:0]           FRAME_SIZE_RESET = 11'd1;
  localparam logic [CFG_DATA_W-1:0] KERNEL_MID_RESET = 48'h0000_0100_0000;
  localparam logic [7:0]            PIX_MAX          = 8'd255;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_pixel;
  } out_item_t;

  // classification of one beat, made by the front end
  typedef struct packed {
    logic has_out;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } rcv_flags_t;

  localparam int FLAGS_W = $bits(rcv_flags_t);

endpackage

@@ sv/rcv_in_if.sv @@
// ----------------------------------------------------------------------------
// rcv_in_if
// Pixel input channel: valid/ready with one input item per beat.
// ----------------------------------------------------------------------------
interface rcv_in_if;
  import rcv_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/rcv_out_if.sv @@
// ----------------------------------------------------------------------------
// rcv_out_if
// Filtered pixel channel: valid/ready with one result item per beat.
// ----------------------------------------------------------------------------
interface rcv_out_if;
  import rcv_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/rcv_cfg_if.sv @@
// ----------------------------------------------------------------------------
// rcv_cfg_if
// Register write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface rcv_cfg_if;
  import rcv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/rcv_front.sv @@
// ----------------------------------------------------------------------------
// rcv_front
// Tracks input and output raster positions, picks the pixel value by position
// and tags each beat with its output and padding flags.
// ----------------------------------------------------------------------------
module rcv_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rcv_pkg::in_item_t                   in_data,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     height,
  input  logic                                size_wr,
  output logic                                push,
  input  logic                                q_full,
  output rcv_pkg::rcv_flags_t                 flags,
  output logic [rcv_pkg::PIX_W-1:0]           pix,
  output logic [$clog2(MAX_WIDTH)-1:0]        col
);
  import rcv_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT+1);
  localparam int LW = $clog2(MAX_WIDTH+2);

  logic [AW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic          in_done;
  logic [LW-1:0] lead;
  logic [AW-1:0] out_col;
  logic [RW-1:0] out_row;
  logic          primed;
  logic          in_wrap;
  logic          out_wrap;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign col      = in_col;

  // classification of the current beat
  always_comb begin
    primed         = (32'(lead) == 32'(width) + 32'd1);
    in_wrap        = (32'(in_col) + 32'd1 >= 32'(width));
    out_wrap       = (32'(out_col) + 32'd1 >= 32'(width));
    flags.has_out  = primed;
    flags.top_ok   = (out_row != '0);
    flags.bot_ok   = (32'(out_row) + 32'd1 < 32'(height));
    flags.left_ok  = (out_col != '0);
    flags.right_ok = !out_wrap;
    flags.last     = !flags.bot_ok && !flags.right_ok;
    pix            = '0;
    if (!in_done && !in_data.func) begin
      pix = {in_data.blue, in_data.green, in_data.red};
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || size_wr || (push && primed && flags.last)) begin
      in_col  <= '0;
      in_row  <= '0;
      in_done <= 1'b0;
      lead    <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (push) begin
      if (in_wrap) begin
        in_col <= '0;
        if (32'(in_row) + 32'd1 >= 32'(height)) begin
          in_done <= 1'b1;
        end else begin
          in_row <= in_row + 1'b1;
        end
      end else begin
        in_col <= in_col + 1'b1;
      end
      if (!primed) begin
        lead <= lead + 1'b1;
      end else if (out_wrap) begin
        out_col <= '0;
        out_row <= out_row + 1'b1;
      end else begin
        out_col <= out_col + 1'b1;
      end
    end
  end

endmodule

@@ sv/rcv_queue.sv @@
// ----------------------------------------------------------------------------
// rcv_queue
// Short FIFO between the classifying front end and the filter back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rcv_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          not_empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [DW-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (32'(count) == DEPTH);
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH-1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH-1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  `RCV_ASSERT(a_q_bound, clk, rst, 32'(count) <= DEPTH, "queue level above depth")
  `RCV_ASSERT(a_q_pop, clk, rst, !pop || not_empty, "pop from empty queue")
  `RCV_ASSERT_NEXT(a_q_keep, clk, rst, full && !pop, full, "full queue lost an entry")

endmodule

@@ sv/rcv_back.sv @@
// ----------------------------------------------------------------------------
// rcv_back
// Line stores, 3x3 window, per-channel multiply, sum and clamp.
// Stages: store read, window shift, products, sum/clamp into output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rcv_back #(
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  output logic                                  pop,
  input  rcv_pkg::rcv_flags_t                   q_flags,
  input  logic [rcv_pkg::PIX_W-1:0]             q_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0]          q_col,
  input  logic [2:0][rcv_pkg::CFG_DATA_W-1:0]   kernel,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rcv_pkg::out_item_t                    out_data
);
  import rcv_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic              adv;
  // line stores
  logic [PIX_W-1:0]  upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0]  middle_line [MAX_WIDTH];
  // store read stage
  logic              a_valid;
  rcv_flags_t        a_flags;
  logic [PIX_W-1:0]  a_pix;
  logic [AW-1:0]     a_col;
  logic [PIX_W-1:0]  up_rd;
  logic [PIX_W-1:0]  mid_rd;
  // window stage
  logic              b_valid;
  rcv_flags_t        b_flags;
  logic [PIX_W-1:0]  win [9];
  // product stage
  logic              c_valid;
  logic              c_last;
  logic signed [PROD_W-1:0] prod [3][9];
  // sum
  logic signed [SUM_W-1:0]  sum [3];
  logic [7:0]               clamped [3];
  logic [8:0]               tap_ok;

  // whole pipe moves unless the output register is held
  assign adv = !out_valid || out_ready;
  assign pop = adv && q_valid;

  // middle store: read old value, write new pixel
  always_ff @(posedge clk) begin
    if (pop) begin
      mid_rd           <= middle_line[q_col];
      middle_line[q_col] <= q_pix;
    end
  end

  // upper store: takes the old middle value from the middle read register, with bypass
  always_ff @(posedge clk) begin
    if (adv && a_valid) begin
      upper_line[a_col] <= mid_rd;
    end
    if (pop) begin
      if (a_valid && a_col == q_col) begin
        up_rd <= mid_rd;
      end else begin
        up_rd <= upper_line[q_col];
      end
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= q_valid;
      b_valid   <= a_valid && a_flags.has_out;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  // store read payload
  always_ff @(posedge clk) begin
    if (pop) begin
      a_flags <= q_flags;
      a_pix   <= q_pix;
      a_col   <= q_col;
    end
  end

  // window shift: right column gets upper, middle and new pixel
  always_ff @(posedge clk) begin
    if (adv) begin
      b_flags <= a_flags;
      if (a_valid) begin
        for (int i = 0; i < 3; i++) begin
          win[i*3+0] <= win[i*3+1];
          win[i*3+1] <= win[i*3+2];
        end
        win[2] <= up_rd;
        win[5] <= mid_rd;
        win[8] <= a_pix;
      end
    end
  end

  // padding mask per tap
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tap_ok[i*3+j] = (i != 0 || b_flags.top_ok) && (i != 2 || b_flags.bot_ok) &&
                        (j != 0 || b_flags.left_ok) && (j != 2 || b_flags.right_ok);
      end
    end
  end

  // products, one per tap and channel; pixel widened so the product keeps all bits
  always_ff @(posedge clk) begin
    if (adv) begin
      c_last <= b_flags.last;
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < 9; k++) begin
          if (tap_ok[k]) begin
            prod[ch][k] <= PROD_W'($signed({1'b0, win[k][ch*8 +: 8]})) *
                           $signed(kernel[k/3][(k%3)*COEF_W +: COEF_W]);
          end else begin
            prod[ch][k] <= '0;
          end
        end
      end
    end
  end

  // sum and clamp
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        sum[ch] = sum[ch] + SUM_W'(prod[ch][k]);
      end
      if (sum[ch] < 0) begin
        clamped[ch] = '0;
      end else if ((sum[ch] >>> COEF_FRAC_BITS) > SUM_W'(PIX_MAX)) begin
        clamped[ch] = PIX_MAX;
      end else begin
        clamped[ch] = 8'(sum[ch] >>> COEF_FRAC_BITS);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_red    <= clamped[0];
      out_data.out_green  <= clamped[1];
      out_data.out_blue   <= clamped[2];
      out_data.last_pixel <= c_last;
    end
  end

  `RCV_ASSERT_NEXT(a_stall_freeze, clk, rst, out_valid && !out_ready, out_valid && $stable(c_valid) && $stable(b_valid), "pipe moved while output held")
  `RCV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, $stable(out_data), "output changed while held")
  `RCV_ASSERT(a_pop_moves, clk, rst, !pop || adv, "store read without pipe advance")

endmodule

@@ sv/rgb_conv3x3_stream.sv @@
// ----------------------------------------------------------------------------
// rgb_conv3x3_stream
// 3x3 zero-padded convolution of a raster RGB stream with a Q8.8 kernel.
//
//   channel   | dir | beat
//   ----------+-----+------------------------------------------------
//   pixels    | in  | func, red, green, blue
//   filtered  | out | out_red, out_green, out_blue, last_pixel
//   cfg       | in  | index, data (register write)
//
// One pixel per clock while the output is not held; an accepted beat passes the
// queue, store read, window, products and sum/clamp into the output register.
// Results lag inputs by frame_width+1 beats; drain beats flush the last row.
// Line stores are single memories, one read and one write per cycle each.
// Reset is synchronous; no store clearing pass, stale entries are masked.
// A held output stalls the back end; the 4-entry queue then fills.
// ----------------------------------------------------------------------------
module rgb_conv3x3_stream #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 1024,
  parameter int COEF_FRAC_BITS = 8
) (
  input logic       clk,
  input logic       rst,
  rcv_in_if.sink    pixels,
  rcv_out_if.source filtered,
  rcv_cfg_if.sink   cfg
);
  import rcv_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH+1);
  localparam int HW    = $clog2(MAX_HEIGHT+1);
  localparam int QDW   = FLAGS_W + PIX_W + AW;
  localparam int QDEPTH = 4;

  logic [10:0]                  frame_width;
  logic [10:0]                  frame_height;
  logic [2:0][CFG_DATA_W-1:0]   kernel;
  logic [WW-1:0]                width;
  logic [HW-1:0]                height;
  logic                         cfg_wr;
  logic                         size_wr;

  logic                         push;
  logic                         q_full;
  rcv_flags_t                   f_flags;
  logic [PIX_W-1:0]             f_pix;
  logic [AW-1:0]                f_col;
  logic [QDW-1:0]               q_out;
  logic                         q_valid;
  logic                         pop;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;
  assign size_wr   = cfg_wr && (cfg.index == REG_FRAME_WIDTH ||
                                cfg.index == REG_FRAME_HEIGHT);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_SIZE_RESET;
      frame_height <= FRAME_SIZE_RESET;
      kernel[0]    <= '0;
      kernel[1]    <= KERNEL_MID_RESET;
      kernel[2]    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data[10:0];
        REG_FRAME_HEIGHT: frame_height <= cfg.data[10:0];
        REG_KERNEL_TOP:   kernel[0]    <= cfg.data;
        REG_KERNEL_MID:   kernel[1]    <= cfg.data;
        REG_KERNEL_BOT:   kernel[2]    <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective frame size: zero acts as one, clipped to the maximum
  always_comb begin
    if (frame_width == '0) begin
      width = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      width = WW'(MAX_WIDTH);
    end else begin
      width = WW'(frame_width);
    end
    if (frame_height == '0) begin
      height = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height = HW'(MAX_HEIGHT);
    end else begin
      height = HW'(frame_height);
    end
  end

  rcv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (pixels.ready),
    .in_data  (pixels.data),
    .width    (width),
    .height   (height),
    .size_wr  (size_wr),
    .push     (push),
    .q_full   (q_full),
    .flags    (f_flags),
    .pix      (f_pix),
    .col      (f_col)
  );

  rcv_queue #(
    .DW    (QDW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_flags, f_pix, f_col}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  rcv_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .pop       (pop),
    .q_flags   (q_out[QDW-1 -: FLAGS_W]),
    .q_pix     (q_out[AW +: PIX_W]),
    .q_col     (q_out[AW-1:0]),
    .kernel    (kernel),
    .out_valid (filtered.valid),
    .out_ready (filtered.ready),
    .out_data  (filtered.data)
  );

endmodule
